// ----- rtl/pdfm_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pdfm_pkg
// Shared types and constants of the PWM duty-cycle and frequency meter.
// ----------------------------------------------------------------------------
package pdfm_pkg;

   localparam int TICK_BITS     = 24;
   localparam int HIGH_BITS     = 16;
   localparam int LOW_BITS      = 16;
   localparam int PERIOD_BITS   = 17;
   localparam int DUTY_BITS     = 7;
   localparam int FREQ_BITS     = 24;
   localparam int SCALE_BITS    = 7;

   localparam logic [TICK_BITS-1:0]  TICK_RATE_RESET = 24'd100000;
   localparam logic [SCALE_BITS-1:0] PERCENT_SCALE   = 7'd100;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PREP,
      ST_DUTY_GO,
      ST_DUTY_RUN,
      ST_FREQ_GO,
      ST_FREQ_RUN,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

   typedef struct packed {
      logic fire;
      logic rising;
   } phase_event_type;

endpackage
`default_nettype wire

// ----- rtl/pwm_duty_frequency_meter.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pwm_duty_frequency_meter
// Measures high time, low time, period, duty cycle and frequency of a
// sampled pulse line.
//
// req_ carries one sample word per tick (req_level). A sample that shows no
// level change is taken without a stall and gives no result. A sample that
// ends a phase starts a computation: ST_PREP forms period and high*100, then,
// unless the period is zero, two divisions run on one shared restoring
// divider of DW = max(COUNT_BITS+7, 24) steps each; req_stall is high for
// the whole computation.
// rsp_ delivers one result word per level change from an output register;
// while rsp_stall is high the word holds and a finished next result waits in
// the sequencer until the register frees.
// csr_ writes tick_rate_hz, the frequency dividend; csr_ready is always high.
// Reset clears counters, latched phases and pending results and sets
// tick_rate_hz to 100000.
// ----------------------------------------------------------------------------
module pwm_duty_frequency_meter #(
   parameter int COUNT_BITS = 16
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire logic                                req_level,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output logic [pdfm_pkg::HIGH_BITS-1:0]           rsp_high_ticks,
   output logic [pdfm_pkg::LOW_BITS-1:0]            rsp_low_ticks,
   output logic [pdfm_pkg::PERIOD_BITS-1:0]         rsp_period_ticks,
   output logic [pdfm_pkg::DUTY_BITS-1:0]           rsp_duty_percent,
   output logic [pdfm_pkg::FREQ_BITS-1:0]           rsp_frequency_hz,
   output logic                                     rsp_rising_edge,
   output logic                                     rsp_invalid,
   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic [pdfm_pkg::TICK_BITS-1:0]      csr_tick_rate_hz
);

   localparam int PBITS = COUNT_BITS + 1;
   localparam int MBITS = COUNT_BITS + pdfm_pkg::SCALE_BITS;
   localparam int DW    = (MBITS > pdfm_pkg::FREQ_BITS) ? MBITS : pdfm_pkg::FREQ_BITS;
   localparam int XBITS = COUNT_BITS + pdfm_pkg::PERIOD_BITS;

   pdfm_pkg::state_type        state_ff, state_in;
   pdfm_pkg::phase_event_type  phase_event;
   pdfm_pkg::div_status_type   div_status;

   logic                             req_accept;
   logic [COUNT_BITS-1:0]            high_latched;
   logic [COUNT_BITS-1:0]            low_latched;
   logic [pdfm_pkg::TICK_BITS-1:0]   tick_rate_ff;
   logic [PBITS-1:0]                 period_ff, period_in;
   logic [MBITS-1:0]                 product_ff, product_in;
   logic                             invalid_ff, invalid_in;
   logic                             rising_ff, rising_in;
   logic [pdfm_pkg::DUTY_BITS-1:0]   duty_ff, duty_in;
   logic [pdfm_pkg::FREQ_BITS-1:0]   freq_ff, freq_in;
   logic                             div_start;
   logic [DW-1:0]                    div_dividend;
   logic [DW-1:0]                    div_quotient;
   logic                             load_rsp;
   logic                             rsp_valid_ff, rsp_valid_in;
   logic [XBITS-1:0]                 high_ext, low_ext, period_ext;

   logic [pdfm_pkg::HIGH_BITS-1:0]   rsp_high_ff;
   logic [pdfm_pkg::LOW_BITS-1:0]    rsp_low_ff;
   logic [pdfm_pkg::PERIOD_BITS-1:0] rsp_period_ff;
   logic [pdfm_pkg::DUTY_BITS-1:0]   rsp_duty_ff;
   logic [pdfm_pkg::FREQ_BITS-1:0]   rsp_freq_ff;
   logic                             rsp_rising_ff;
   logic                             rsp_invalid_ff;

   assign req_stall  = (state_ff != pdfm_pkg::ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign csr_ready  = 1'b1;

   pdfm_phase #(
      .COUNT_BITS (COUNT_BITS)
   ) u_phase (
      .clock        (clock),
      .reset        (reset),
      .sample       (req_accept),
      .level        (req_level),
      .event_out    (phase_event),
      .high_latched (high_latched),
      .low_latched  (low_latched)
   );

   pdfm_divider #(
      .DIVIDEND_BITS (DW),
      .DIVISOR_BITS  (PBITS)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (period_ff),
      .quotient (div_quotient),
      .status   (div_status)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         pdfm_pkg::ST_IDLE: begin
            if (req_accept && phase_event.fire) begin
               state_in = pdfm_pkg::ST_PREP;
            end
         end
         pdfm_pkg::ST_PREP: begin
            state_in = invalid_in ? pdfm_pkg::ST_OUT : pdfm_pkg::ST_DUTY_GO;
         end
         pdfm_pkg::ST_DUTY_GO: begin
            state_in = pdfm_pkg::ST_DUTY_RUN;
         end
         pdfm_pkg::ST_DUTY_RUN: begin
            if (div_status.done) begin
               state_in = pdfm_pkg::ST_FREQ_GO;
            end
         end
         pdfm_pkg::ST_FREQ_GO: begin
            state_in = pdfm_pkg::ST_FREQ_RUN;
         end
         pdfm_pkg::ST_FREQ_RUN: begin
            if (div_status.done) begin
               state_in = pdfm_pkg::ST_OUT;
            end
         end
         pdfm_pkg::ST_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               state_in = pdfm_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = pdfm_pkg::ST_IDLE;
         end
      endcase
   end

   // outputs and datapath
   always_comb begin
      period_in    = period_ff;
      product_in   = product_ff;
      invalid_in   = invalid_ff;
      rising_in    = rising_ff;
      duty_in      = duty_ff;
      freq_in      = freq_ff;
      div_start    = 1'b0;
      div_dividend = DW'(product_ff);
      load_rsp     = 1'b0;
      case (state_ff)
         pdfm_pkg::ST_IDLE: begin
            if (req_accept) begin
               rising_in = phase_event.rising;
            end
         end
         pdfm_pkg::ST_PREP: begin
            period_in  = PBITS'(high_latched) + PBITS'(low_latched);
            product_in = MBITS'(high_latched) * MBITS'(pdfm_pkg::PERCENT_SCALE);
            invalid_in = (period_in == '0);
            duty_in    = '0;
            freq_in    = '0;
         end
         pdfm_pkg::ST_DUTY_GO: begin
            div_start    = 1'b1;
            div_dividend = DW'(product_ff);
         end
         pdfm_pkg::ST_DUTY_RUN: begin
            if (div_status.done) begin
               duty_in = div_quotient[pdfm_pkg::DUTY_BITS-1:0];
            end
         end
         pdfm_pkg::ST_FREQ_GO: begin
            div_start    = 1'b1;
            div_dividend = DW'(tick_rate_ff);
         end
         pdfm_pkg::ST_FREQ_RUN: begin
            if (div_status.done) begin
               freq_in = div_quotient[pdfm_pkg::FREQ_BITS-1:0];
            end
         end
         pdfm_pkg::ST_OUT: begin
            load_rsp = !rsp_valid_ff || !rsp_stall;
         end
         default: begin
            load_rsp = 1'b0;
         end
      endcase
   end

   assign high_ext   = XBITS'(high_latched);
   assign low_ext    = XBITS'(low_latched);
   assign period_ext = XBITS'(period_ff);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      period_ff  <= period_in;
      product_ff <= product_in;
      invalid_ff <= invalid_in;
      rising_ff  <= rising_in;
      duty_ff    <= duty_in;
      freq_ff    <= freq_in;
      if (load_rsp) begin
         rsp_high_ff    <= high_ext[pdfm_pkg::HIGH_BITS-1:0];
         rsp_low_ff     <= low_ext[pdfm_pkg::LOW_BITS-1:0];
         rsp_period_ff  <= period_ext[pdfm_pkg::PERIOD_BITS-1:0];
         rsp_duty_ff    <= duty_ff;
         rsp_freq_ff    <= freq_ff;
         rsp_rising_ff  <= rising_ff;
         rsp_invalid_ff <= invalid_ff;
      end
      if (reset) begin
         state_ff     <= pdfm_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
         tick_rate_ff <= pdfm_pkg::TICK_RATE_RESET;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            tick_rate_ff <= csr_tick_rate_hz;
         end
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_high_ticks   = rsp_high_ff;
   assign rsp_low_ticks    = rsp_low_ff;
   assign rsp_period_ticks = rsp_period_ff;
   assign rsp_duty_percent = rsp_duty_ff;
   assign rsp_frequency_hz = rsp_freq_ff;
   assign rsp_rising_edge  = rsp_rising_ff;
   assign rsp_invalid      = rsp_invalid_ff;

endmodule
`default_nettype wire

// ----- rtl/pdfm_divider.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pdfm_divider
// Shared restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pdfm_divider #(
   parameter int DIVIDEND_BITS = 24,
   parameter int DIVISOR_BITS  = 17
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       start,
   input  wire logic [DIVIDEND_BITS-1:0]   dividend,
   input  wire logic [DIVISOR_BITS-1:0]    divisor,
   output logic [DIVIDEND_BITS-1:0]        quotient,
   output pdfm_pkg::div_status_type        status
);

   localparam int CNT_BITS = $clog2(DIVIDEND_BITS + 1);

   logic [DIVISOR_BITS-1:0]  rem_ff, rem_in;
   logic [DIVIDEND_BITS-1:0] quo_ff, quo_in;
   logic [DIVISOR_BITS-1:0]  divisor_ff, divisor_in;
   logic [CNT_BITS-1:0]      cnt_ff, cnt_in;
   logic                     busy_ff, busy_in;
   logic                     done_ff, done_in;

   logic [DIVISOR_BITS:0]    trial;
   logic [DIVISOR_BITS:0]    diff;
   logic                     fits;

   assign trial = {rem_ff, quo_ff[DIVIDEND_BITS-1]};
   assign diff  = trial - {1'b0, divisor_ff};
   assign fits  = trial >= {1'b0, divisor_ff};

   always_comb begin
      rem_in     = rem_ff;
      quo_in     = quo_ff;
      divisor_in = divisor_ff;
      cnt_in     = cnt_ff;
      busy_in    = busy_ff;
      done_in    = 1'b0;
      if (start) begin
         rem_in     = '0;
         quo_in     = dividend;
         divisor_in = divisor;
         cnt_in     = CNT_BITS'(DIVIDEND_BITS);
         busy_in    = 1'b1;
      end else if (busy_ff) begin
         rem_in = fits ? diff[DIVISOR_BITS-1:0] : trial[DIVISOR_BITS-1:0];
         quo_in = {quo_ff[DIVIDEND_BITS-2:0], fits};
         cnt_in = cnt_ff - CNT_BITS'(1);
         if (cnt_ff == CNT_BITS'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff     <= rem_in;
      quo_ff     <= quo_in;
      divisor_ff <= divisor_in;
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign quotient    = quo_ff;
   assign status.busy = busy_ff;
   assign status.done = done_ff;

endmodule
`default_nettype wire

// ----- rtl/pdfm_phase.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pdfm_phase
// Saturating high and low phase counters with latching on level change.
// ----------------------------------------------------------------------------
module pdfm_phase #(
   parameter int COUNT_BITS = 16
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   sample,
   input  wire logic                   level,
   output pdfm_pkg::phase_event_type   event_out,
   output logic [COUNT_BITS-1:0]       high_latched,
   output logic [COUNT_BITS-1:0]       low_latched
);

   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

   logic [COUNT_BITS-1:0] high_cnt_ff, high_cnt_in;
   logic [COUNT_BITS-1:0] low_cnt_ff, low_cnt_in;
   logic [COUNT_BITS-1:0] high_lat_ff, high_lat_in;
   logic [COUNT_BITS-1:0] low_lat_ff, low_lat_in;
   logic                  phase_high_ff, phase_high_in;
   logic                  fire;

   assign fire = sample && (level == phase_high_ff);

   always_comb begin
      high_cnt_in   = high_cnt_ff;
      low_cnt_in    = low_cnt_ff;
      high_lat_in   = high_lat_ff;
      low_lat_in    = low_lat_ff;
      phase_high_in = phase_high_ff;
      if (sample) begin
         if (level) begin
            if (high_cnt_ff != COUNT_MAX) begin
               high_cnt_in = high_cnt_ff + COUNT_BITS'(1);
            end
            if (fire) begin
               low_lat_in    = low_cnt_ff;
               low_cnt_in    = '0;
               phase_high_in = 1'b0;
            end
         end else begin
            if (low_cnt_ff != COUNT_MAX) begin
               low_cnt_in = low_cnt_ff + COUNT_BITS'(1);
            end
            if (fire) begin
               high_lat_in   = high_cnt_ff;
               high_cnt_in   = '0;
               phase_high_in = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         high_cnt_ff   <= '0;
         low_cnt_ff    <= '0;
         high_lat_ff   <= '0;
         low_lat_ff    <= '0;
         phase_high_ff <= 1'b0;
      end else begin
         high_cnt_ff   <= high_cnt_in;
         low_cnt_ff    <= low_cnt_in;
         high_lat_ff   <= high_lat_in;
         low_lat_ff    <= low_lat_in;
         phase_high_ff <= phase_high_in;
      end
   end

   assign event_out.fire   = fire;
   assign event_out.rising = level;
   assign high_latched     = high_lat_ff;
   assign low_latched      = low_lat_ff;

endmodule
`default_nettype wire

// ----- rtl/pdfm_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pdfm_checker
// Port-level checks of the PWM duty-cycle and frequency meter.
// ----------------------------------------------------------------------------
module pdfm_checker (
   input wire logic                                clock,
   input wire logic                                reset,
   input wire logic                                rsp_valid,
   input wire logic                                rsp_stall,
   input wire logic [pdfm_pkg::PERIOD_BITS-1:0]    rsp_period_ticks,
   input wire logic [pdfm_pkg::DUTY_BITS-1:0]      rsp_duty_percent,
   input wire logic [pdfm_pkg::FREQ_BITS-1:0]      rsp_frequency_hz,
   input wire logic                                rsp_invalid
);

   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result word valid after reset");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_duty_percent)
         && $stable(rsp_frequency_hz) && $stable(rsp_period_ticks))
      else $error("stalled result word changed");

   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_invalid |-> rsp_duty_percent == '0
         && rsp_frequency_hz == '0 && rsp_period_ticks == '0)
      else $error("invalid result word carries nonzero values");

   a_duty_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_duty_percent <= pdfm_pkg::DUTY_BITS'(pdfm_pkg::PERCENT_SCALE))
      else $error("duty above full scale");

endmodule

bind pwm_duty_frequency_meter pdfm_checker u_pdfm_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_period_ticks (rsp_period_ticks),
   .rsp_duty_percent (rsp_duty_percent),
   .rsp_frequency_hz (rsp_frequency_hz),
   .rsp_invalid      (rsp_invalid)
);
`default_nettype wire
